### rtl/resource_holder_and_wait_tracker_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the resource holder and wait tracker.
// Each macro expands to one labeled concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef RESOURCE_HOLDER_AND_WAIT_TRACKER_MACROS_SVH
`define RESOURCE_HOLDER_AND_WAIT_TRACKER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RHT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/rht_pkg.sv
// ----------------------------------------------------------------------------
// rht_pkg
// Shared types and constants of the resource holder and wait tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rht_pkg;

   // Fixed field widths of the request and response words.
   localparam int MODE_W    = 2;
   localparam int RES_W     = 3;
   localparam int ID_W      = 8;
   localparam int STATUS_W  = 3;
   localparam int CAP_W     = 3;
   localparam int CSR_IDX_W = 2;

   // Resource index widened far enough to compare against resource counts below 128.
   localparam int RES_EXT_W = 7;

   // Configuration register indexes and reset values.
   localparam logic [CSR_IDX_W-1:0] CSR_EVEN_CAP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ODD_CAP  = 2'd1;
   localparam logic [CAP_W-1:0] EVEN_CAP_RESET = 3'd1;
   localparam logic [CAP_W-1:0] ODD_CAP_RESET  = 3'd3;

   typedef enum logic [MODE_W-1:0] {
      MODE_ADD     = 2'd0,
      MODE_REMOVE  = 2'd1,
      MODE_ENQUEUE = 2'd2,
      MODE_DEQUEUE = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE      = 3'd0,
      ST_AT_CAP    = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_FULL      = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   // Request handed to the engine on acceptance.
   typedef struct packed {
      logic            start;
      mode_type        mode;
      logic            in_range;
      logic [ID_W-1:0] requester;
   } cmd_type;

   // Engine completion.
   typedef struct packed {
      logic            done;
      status_type      status;
      logic [ID_W-1:0] dequeued_id;
   } result_type;

endpackage

`default_nettype wire

### rtl/rht_ram.sv
// ----------------------------------------------------------------------------
// rht_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/rht_engine.sv
// ----------------------------------------------------------------------------
// rht_engine
// Sequencer that runs one request against the holder and waiter memories,
// stepping a shared slot index and compare unit for search and compaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rht_engine #(
   parameter int NUM_RESOURCES = 8,
   parameter int WAIT_DEPTH    = 16,
   parameter int HOLDER_DEPTH  = 4,
   localparam int RIDX_W  = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1,
   localparam int HC_W    = $clog2(HOLDER_DEPTH + 1),
   localparam int WC_W    = $clog2(WAIT_DEPTH + 1),
   localparam int WPOS_W  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rht_pkg::cmd_type     cmd,
   input  logic [RIDX_W-1:0]    cmd_res,
   input  logic [HC_W-1:0]      cmd_hc,
   input  logic [HC_W-1:0]      cmd_limit,
   input  logic [WC_W-1:0]      cmd_wc,
   input  logic [WPOS_W-1:0]    cmd_head,
   input  logic                 ack,
   output rht_pkg::result_type  result,
   output logic [HC_W-1:0]      result_hc,
   output logic [WC_W-1:0]      result_wc,
   output logic [WPOS_W-1:0]    result_head
);

   import rht_pkg::*;

   localparam int HSLOT_W = (HOLDER_DEPTH > 1) ? $clog2(HOLDER_DEPTH) : 1;
   localparam int HMEM_D  = NUM_RESOURCES * HOLDER_DEPTH;
   localparam int WMEM_D  = NUM_RESOURCES * WAIT_DEPTH;
   localparam int HADDR_W = (HMEM_D > 1) ? $clog2(HMEM_D) : 1;
   localparam int WADDR_W = (WMEM_D > 1) ? $clog2(WMEM_D) : 1;

   typedef enum logic [9:0] {
      S_IDLE    = 10'b0000000001,
      S_ADD     = 10'b0000000010,
      S_ENQ     = 10'b0000000100,
      S_DQ_RD   = 10'b0000001000,
      S_DQ_DATA = 10'b0000010000,
      S_RM_RD   = 10'b0000100000,
      S_RM_CMP  = 10'b0001000000,
      S_SH_RD   = 10'b0010000000,
      S_SH_WR   = 10'b0100000000,
      S_FINISH  = 10'b1000000000
   } state_type;

   state_type         state_ff, state_in;
   logic [RIDX_W-1:0] res_ff, res_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [HC_W-1:0]   hc_ff, hc_in;
   logic [WC_W-1:0]   wc_ff, wc_in;
   logic [WPOS_W-1:0] head_ff, head_in;
   logic [HC_W-1:0]   idx_ff, idx_in;
   status_type        status_ff, status_in;
   logic [ID_W-1:0]   deq_ff, deq_in;

   logic [HC_W-1:0]    idx_inc;
   logic [HC_W-1:0]    hc_dec;
   logic [HC_W-1:0]    hslot;
   logic [HADDR_W-1:0] haddr;
   logic [WC_W:0]      wend_sum;
   logic [WC_W:0]      wend_wrap;
   logic [WC_W:0]      head_sum;
   logic [WC_W:0]      head_wrap;
   logic [WPOS_W-1:0]  wslot;
   logic [WADDR_W-1:0] waddr;

   logic            h_wr_en;
   logic [ID_W-1:0] h_wr_data;
   logic            h_rd_en;
   logic [ID_W-1:0] h_rd_data;
   logic            w_wr_en;
   logic            w_rd_en;
   logic [ID_W-1:0] w_rd_data;

   // Shared slot index unit: increment, compare and holder address.
   assign idx_inc = idx_ff + HC_W'(1);
   assign hc_dec  = hc_ff - HC_W'(1);

   always_comb begin
      case (state_ff)
         S_ADD:   hslot = hc_ff;
         S_SH_RD: hslot = idx_inc;
         default: hslot = idx_ff;
      endcase
   end

   assign haddr = HADDR_W'(res_ff) * HADDR_W'(HOLDER_DEPTH)
                + HADDR_W'(hslot[HSLOT_W-1:0]);

   // Circular waiter positions: tail for enqueue, next head for dequeue.
   assign wend_sum  = (WC_W + 1)'(head_ff) + (WC_W + 1)'(wc_ff);
   assign wend_wrap = (wend_sum >= (WC_W + 1)'(WAIT_DEPTH))
                    ? wend_sum - (WC_W + 1)'(WAIT_DEPTH) : wend_sum;
   assign head_sum  = (WC_W + 1)'(head_ff) + (WC_W + 1)'(1);
   assign head_wrap = (head_sum >= (WC_W + 1)'(WAIT_DEPTH))
                    ? head_sum - (WC_W + 1)'(WAIT_DEPTH) : head_sum;

   assign wslot = (state_ff == S_DQ_RD) ? head_ff : wend_wrap[WPOS_W-1:0];
   assign waddr = WADDR_W'(res_ff) * WADDR_W'(WAIT_DEPTH) + WADDR_W'(wslot);

   // Memory controls.
   assign h_wr_en   = (state_ff == S_ADD) || (state_ff == S_SH_WR);
   assign h_wr_data = (state_ff == S_ADD) ? id_ff : h_rd_data;
   assign h_rd_en   = (state_ff == S_RM_RD) || (state_ff == S_SH_RD);
   assign w_wr_en   = (state_ff == S_ENQ);
   assign w_rd_en   = (state_ff == S_DQ_RD);

   rht_ram #(
      .WIDTH (ID_W),
      .DEPTH (HMEM_D)
   ) u_holder_ram (
      .clock   (clock),
      .wr_en   (h_wr_en),
      .wr_addr (haddr),
      .wr_data (h_wr_data),
      .rd_en   (h_rd_en),
      .rd_addr (haddr),
      .rd_data (h_rd_data)
   );

   rht_ram #(
      .WIDTH (ID_W),
      .DEPTH (WMEM_D)
   ) u_wait_ram (
      .clock   (clock),
      .wr_en   (w_wr_en),
      .wr_addr (waddr),
      .wr_data (id_ff),
      .rd_en   (w_rd_en),
      .rd_addr (waddr),
      .rd_data (w_rd_data)
   );

   // Sequencer next state.
   always_comb begin
      state_in  = state_ff;
      res_in    = res_ff;
      id_in     = id_ff;
      hc_in     = hc_ff;
      wc_in     = wc_ff;
      head_in   = head_ff;
      idx_in    = idx_ff;
      status_in = status_ff;
      deq_in    = deq_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               res_in    = cmd_res;
               id_in     = cmd.requester;
               hc_in     = cmd_hc;
               wc_in     = cmd_wc;
               head_in   = cmd_head;
               idx_in    = '0;
               deq_in    = '0;
               status_in = ST_DONE;
               state_in  = S_FINISH;
               if (!cmd.in_range) begin
                  hc_in     = '0;
                  wc_in     = '0;
                  head_in   = '0;
                  status_in = ST_NOT_FOUND;
               end else begin
                  case (cmd.mode)
                     MODE_ADD: begin
                        if (cmd_hc < cmd_limit) begin
                           state_in = S_ADD;
                        end else begin
                           status_in = ST_AT_CAP;
                        end
                     end
                     MODE_REMOVE: begin
                        if (cmd_hc != '0) begin
                           state_in = S_RM_RD;
                        end else begin
                           status_in = ST_NOT_FOUND;
                        end
                     end
                     MODE_ENQUEUE: begin
                        if (cmd_wc < WC_W'(WAIT_DEPTH)) begin
                           state_in = S_ENQ;
                        end else begin
                           status_in = ST_FULL;
                        end
                     end
                     default: begin
                        if (cmd_wc != '0) begin
                           state_in = S_DQ_RD;
                        end else begin
                           status_in = ST_EMPTY;
                        end
                     end
                  endcase
               end
            end
         end
         S_ADD: begin
            hc_in    = hc_ff + HC_W'(1);
            state_in = S_FINISH;
         end
         S_ENQ: begin
            wc_in    = wc_ff + WC_W'(1);
            state_in = S_FINISH;
         end
         S_DQ_RD: begin
            state_in = S_DQ_DATA;
         end
         S_DQ_DATA: begin
            deq_in   = w_rd_data;
            head_in  = head_wrap[WPOS_W-1:0];
            wc_in    = wc_ff - WC_W'(1);
            state_in = S_FINISH;
         end
         S_RM_RD: begin
            state_in = S_RM_CMP;
         end
         S_RM_CMP: begin
            if (h_rd_data == id_ff) begin
               // Match: close the gap unless it was the last holder.
               if (idx_inc < hc_ff) begin
                  state_in = S_SH_RD;
               end else begin
                  hc_in    = hc_dec;
                  state_in = S_FINISH;
               end
            end else if (idx_inc < hc_ff) begin
               idx_in   = idx_inc;
               state_in = S_RM_RD;
            end else begin
               status_in = ST_NOT_FOUND;
               state_in  = S_FINISH;
            end
         end
         S_SH_RD: begin
            state_in = S_SH_WR;
         end
         S_SH_WR: begin
            idx_in = idx_inc;
            if (idx_inc < hc_dec) begin
               state_in = S_SH_RD;
            end else begin
               hc_in    = hc_dec;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (ack) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Sequencer state and working registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      res_ff    <= res_in;
      id_ff     <= id_in;
      hc_ff     <= hc_in;
      wc_ff     <= wc_in;
      head_ff   <= head_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      deq_ff    <= deq_in;
   end

   assign result.done        = (state_ff == S_FINISH);
   assign result.status      = status_ff;
   assign result.dequeued_id = deq_ff;
   assign result_hc          = hc_ff;
   assign result_wc          = wc_ff;
   assign result_head        = head_ff;

endmodule

`default_nettype wire

### rtl/resource_holder_and_wait_tracker.sv
// ----------------------------------------------------------------------------
// resource_holder_and_wait_tracker
// Per-resource holder lists and waiter queues behind a request and response
// word interface, with two holder capacity registers.
// ----------------------------------------------------------------------------
// Every request word yields exactly one response word, and one request is
// in flight at a time. A rejected request, or one aimed at a resource out
// of range, goes straight to the finish state; add and enqueue pass through
// one write state, dequeue reads the waiter memory and then takes the data,
// and remove searches the holder list and closes the gap after a match, one
// slot at a time through the single read port of the holder memory. The
// response word is loaded into the output register once that register is
// free. A new request can be taken in the cycle after the response is
// loaded, even while that response waits. The waiter queues are circular
// buffers, so a dequeue costs one memory read. Capacity registers are
// written through the csr_ port, which is always ready; writes to indexes
// past the odd capacity register are ignored.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "resource_holder_and_wait_tracker_macros.svh"

module resource_holder_and_wait_tracker #(
   parameter int NUM_RESOURCES = 8,
   parameter int WAIT_DEPTH    = 16,
   parameter int HOLDER_DEPTH  = 4,
   localparam int HC_W = $clog2(HOLDER_DEPTH + 1),
   localparam int WC_W = $clog2(WAIT_DEPTH + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   // Configuration writes.
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rht_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rht_pkg::CAP_W-1:0]      csr_data,
   // Request words.
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [rht_pkg::MODE_W-1:0]     req_mode,
   input  logic [rht_pkg::RES_W-1:0]      req_resource,
   input  logic [rht_pkg::ID_W-1:0]       req_requester,
   // Response words.
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [rht_pkg::STATUS_W-1:0]   rsp_status,
   output logic [rht_pkg::ID_W-1:0]       rsp_dequeued_id,
   output logic [HC_W-1:0]                rsp_holder_count,
   output logic [WC_W-1:0]                rsp_waiter_count
);

   import rht_pkg::*;

   localparam int RIDX_W = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
   localparam int WPOS_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;

   logic [CAP_W-1:0] even_cap_ff, even_cap_in;
   logic [CAP_W-1:0] odd_cap_ff, odd_cap_in;

   logic [HC_W-1:0]   hcnt_ff [NUM_RESOURCES];
   logic [HC_W-1:0]   hcnt_in [NUM_RESOURCES];
   logic [WC_W-1:0]   wcnt_ff [NUM_RESOURCES];
   logic [WC_W-1:0]   wcnt_in [NUM_RESOURCES];
   logic [WPOS_W-1:0] head_ff [NUM_RESOURCES];
   logic [WPOS_W-1:0] head_in [NUM_RESOURCES];

   logic              busy_ff, busy_in;
   logic [RIDX_W-1:0] res_ff, res_in;
   logic              in_range_ff, in_range_in;
   mode_type          mode_ff, mode_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]     rsp_deq_ff, rsp_deq_in;
   logic [HC_W-1:0]     rsp_hc_ff, rsp_hc_in;
   logic [WC_W-1:0]     rsp_wc_ff, rsp_wc_in;

   logic [RES_EXT_W-1:0] res_ext;
   logic                 req_in_range;
   logic [RIDX_W-1:0]    req_idx;
   logic [CAP_W-1:0]     cap_sel;
   logic [HC_W-1:0]      limit;
   logic                 accept;
   logic                 ack;

   cmd_type           eng_cmd;
   logic [HC_W-1:0]   eng_cmd_hc;
   logic [WC_W-1:0]   eng_cmd_wc;
   logic [WPOS_W-1:0] eng_cmd_head;
   result_type        eng_result;
   logic [HC_W-1:0]   eng_hc;
   logic [WC_W-1:0]   eng_wc;
   logic [WPOS_W-1:0] eng_head;

   // Handshakes.
   assign csr_ready = 1'b1;
   assign req_ready = !busy_ff;
   assign accept    = req_valid && req_ready;
   assign ack       = eng_result.done && (!rsp_valid_ff || rsp_ready);

   // Capacity registers.
   always_comb begin
      even_cap_in = even_cap_ff;
      odd_cap_in  = odd_cap_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_EVEN_CAP: even_cap_in = csr_data;
            CSR_ODD_CAP:  odd_cap_in  = csr_data;
            default:      ;
         endcase
      end
   end

   // Decode the addressed resource and its holder limit.
   assign res_ext      = RES_EXT_W'(req_resource);
   assign req_in_range = res_ext < RES_EXT_W'(NUM_RESOURCES);
   assign req_idx      = res_ext[RIDX_W-1:0];
   assign cap_sel      = req_resource[0] ? odd_cap_ff : even_cap_ff;
   assign limit        = (int'(cap_sel) > HOLDER_DEPTH) ? HC_W'(HOLDER_DEPTH)
                                                        : HC_W'(cap_sel);

   // Table lookups for the engine.
   assign eng_cmd.start     = accept;
   assign eng_cmd.mode      = mode_type'(req_mode);
   assign eng_cmd.in_range  = req_in_range;
   assign eng_cmd.requester = req_requester;
   assign eng_cmd_hc        = req_in_range ? hcnt_ff[req_idx] : '0;
   assign eng_cmd_wc        = req_in_range ? wcnt_ff[req_idx] : '0;
   assign eng_cmd_head      = req_in_range ? head_ff[req_idx] : '0;

   rht_engine #(
      .NUM_RESOURCES (NUM_RESOURCES),
      .WAIT_DEPTH    (WAIT_DEPTH),
      .HOLDER_DEPTH  (HOLDER_DEPTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .cmd         (eng_cmd),
      .cmd_res     (req_idx),
      .cmd_hc      (eng_cmd_hc),
      .cmd_limit   (limit),
      .cmd_wc      (eng_cmd_wc),
      .cmd_head    (eng_cmd_head),
      .ack         (ack),
      .result      (eng_result),
      .result_hc   (eng_hc),
      .result_wc   (eng_wc),
      .result_head (eng_head)
   );

   // Request tracking and table write-back on completion.
   always_comb begin
      busy_in     = busy_ff;
      res_in      = res_ff;
      in_range_in = in_range_ff;
      mode_in     = mode_ff;
      hcnt_in     = hcnt_ff;
      wcnt_in     = wcnt_ff;
      head_in     = head_ff;
      if (accept) begin
         busy_in     = 1'b1;
         res_in      = req_idx;
         in_range_in = req_in_range;
         mode_in     = mode_type'(req_mode);
      end
      if (ack) begin
         busy_in = 1'b0;
         if (in_range_ff) begin
            hcnt_in[res_ff] = eng_hc;
            wcnt_in[res_ff] = eng_wc;
            head_in[res_ff] = eng_head;
         end
      end
   end

   // Response output register.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_deq_in    = rsp_deq_ff;
      rsp_hc_in     = rsp_hc_ff;
      rsp_wc_in     = rsp_wc_ff;
      if (ack) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = eng_result.status;
         rsp_deq_in    = eng_result.dequeued_id;
         rsp_hc_in     = eng_hc;
         rsp_wc_in     = eng_wc;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         even_cap_ff  <= EVEN_CAP_RESET;
         odd_cap_ff   <= ODD_CAP_RESET;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_RESOURCES; i++) begin
            hcnt_ff[i] <= '0;
            wcnt_ff[i] <= '0;
            head_ff[i] <= '0;
         end
      end else begin
         even_cap_ff  <= even_cap_in;
         odd_cap_ff   <= odd_cap_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         hcnt_ff      <= hcnt_in;
         wcnt_ff      <= wcnt_in;
         head_ff      <= head_in;
      end
      res_ff        <= res_in;
      in_range_ff   <= in_range_in;
      mode_ff       <= mode_in;
      rsp_status_ff <= rsp_status_in;
      rsp_deq_ff    <= rsp_deq_in;
      rsp_hc_ff     <= rsp_hc_in;
      rsp_wc_ff     <= rsp_wc_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_dequeued_id  = rsp_deq_ff;
   assign rsp_holder_count = rsp_hc_ff;
   assign rsp_waiter_count = rsp_wc_ff;

   // The engine only completes a request that was accepted.
   `RHT_ASSERT_IMPLY(a_done_while_busy, clock, reset, eng_result.done, busy_ff, "engine done while idle")

   // An accepted word closes the request port in the next cycle.
   `RHT_ASSERT_NEXT(a_accept_blocks, clock, reset, accept, busy_ff && !req_ready, "request port open while busy")

   // A successful add grows the holder count by exactly one.
   `RHT_ASSERT_IMPLY(a_add_grows, clock, reset, ack && in_range_ff && (mode_ff == MODE_ADD) && (eng_result.status == ST_DONE), eng_hc == hcnt_ff[res_ff] + HC_W'(1), "add did not grow holder count")

   // Written-back counts never exceed the store depths.
   `RHT_ASSERT_IMPLY(a_counts_bounded, clock, reset, ack, (eng_hc <= HC_W'(HOLDER_DEPTH)) && (eng_wc <= WC_W'(WAIT_DEPTH)), "count beyond depth")

endmodule

`default_nettype wire
